### hw/rtl/krb_pkg.sv
// ============================================================================
// krb_pkg - shared types and constants of the keyboard ring buffer
// Ring sizing, action and length codes, special-key table.
// ============================================================================
`default_nettype none

package krb_pkg;

    localparam int RING_DEPTH    = 16;
    localparam int PTR_W         = $clog2(RING_DEPTH);
    localparam int KEY_W         = 16;
    localparam int SPECIAL_COUNT = 21;
    localparam int TABLE_LEN     = 21;
    localparam int LAST_IDX      = ((SPECIAL_COUNT < TABLE_LEN) ? SPECIAL_COUNT : TABLE_LEN) - 1;
    localparam int TBL_IDX_W     = (TABLE_LEN > 1) ? $clog2(TABLE_LEN) : 1;

    localparam logic [PTR_W-1:0] PTR_LAST       = PTR_W'(RING_DEPTH - 1);
    localparam logic [KEY_W-1:0] SPECIAL_BASE   = KEY_W'(16'h0100);
    localparam logic [KEY_W-1:0] LAST_IDX_KEY   = KEY_W'(LAST_IDX);
    localparam logic [7:0]       SPECIAL_PREFIX = 8'hFF;

    typedef enum logic {
        ACT_POST = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        LEN_EMPTY   = 2'd0,
        LEN_PLAIN   = 2'd1,
        LEN_SPECIAL = 2'd2
    } length_t;

    // control from the pipeline to the ring
    typedef struct packed {
        logic             post_en;
        logic             read_en;
        logic [KEY_W-1:0] code;
    } ring_op_t;

    // answer of the ring to a read
    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] key;
    } ring_rsp_t;

    typedef struct packed {
        length_t    length;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } enc_t;

    function automatic logic [7:0] special_char(input logic [TBL_IDX_W-1:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                TBL_IDX_W'(0):  c = "X";
                TBL_IDX_W'(1):  c = "H";
                TBL_IDX_W'(2):  c = "P";
                TBL_IDX_W'(3):  c = "K";
                TBL_IDX_W'(4):  c = "M";
                TBL_IDX_W'(5):  c = "R";
                TBL_IDX_W'(6):  c = "S";
                TBL_IDX_W'(7):  c = "G";
                TBL_IDX_W'(8):  c = "O";
                TBL_IDX_W'(9):  c = "I";
                TBL_IDX_W'(10): c = "Q";
                TBL_IDX_W'(11): c = ";";
                TBL_IDX_W'(12): c = "<";
                TBL_IDX_W'(13): c = "=";
                TBL_IDX_W'(14): c = ">";
                TBL_IDX_W'(15): c = "?";
                TBL_IDX_W'(16): c = "@";
                TBL_IDX_W'(17): c = "A";
                TBL_IDX_W'(18): c = "B";
                TBL_IDX_W'(19): c = "C";
                default:        c = "D";
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/krb_ring.sv
// ============================================================================
// krb_ring - key storage ring with overwrite-oldest
// Holds up to RING_DEPTH-1 keys; a post into a full ring drops the oldest.
// ============================================================================
`default_nettype none

module krb_ring (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire krb_pkg::ring_op_t  op,
    output krb_pkg::ring_rsp_t      rsp
);
    import krb_pkg::*;

    logic [KEY_W-1:0] key_store_reg [RING_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] wr_inc, rd_inc;
    logic             empty;

    assign wr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign empty  = (rd_ptr_reg == wr_ptr_reg);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        rsp.hit     = 1'b0;
        rsp.key     = key_store_reg[rd_ptr_reg];
        if (op.post_en)
        begin
            wr_ptr_next = wr_inc;
            // full ring: drop the oldest key
            if (wr_inc == rd_ptr_reg)
                rd_ptr_next = rd_inc;
        end
        else if (op.read_en && !empty)
        begin
            rsp.hit     = 1'b1;
            rd_ptr_next = rd_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.post_en)
            key_store_reg[wr_ptr_reg] <= op.code;
    end

    // a post always leaves at least one key in the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        op.post_en |=> (rd_ptr_reg != wr_ptr_reg))
        else $error("ring empty after post");

    // a read of an empty ring must not move the read pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        (op.read_en && !op.post_en && empty) |=> $stable(rd_ptr_reg))
        else $error("read pointer moved on empty read");

    // a read never moves the write pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        (!op.post_en) |=> $stable(wr_ptr_reg))
        else $error("write pointer moved without post");

endmodule

`default_nettype wire

### hw/rtl/krb_encode.sv
// ============================================================================
// krb_encode - inkey-style key encoder
// Plain codes give one byte, special codes 0xFF plus a table character.
// ============================================================================
`default_nettype none

module krb_encode (
    input  wire logic [krb_pkg::KEY_W-1:0] key,
    output krb_pkg::enc_t                  enc
);
    import krb_pkg::*;

    logic [KEY_W-1:0]     diff;
    logic [TBL_IDX_W-1:0] idx;

    assign diff = key - SPECIAL_BASE;
    // clamp past the end of the table
    assign idx  = (diff > LAST_IDX_KEY) ? TBL_IDX_W'(LAST_IDX) : diff[TBL_IDX_W-1:0];

    always_comb
    begin
        enc.length      = LEN_EMPTY;
        enc.first_byte  = 8'h00;
        enc.second_byte = 8'h00;
        if (key >= SPECIAL_BASE)
        begin
            enc.length      = LEN_SPECIAL;
            enc.first_byte  = SPECIAL_PREFIX;
            enc.second_byte = special_char(idx);
        end
        else if (key != '0)
        begin
            enc.length     = LEN_PLAIN;
            enc.first_byte = key[7:0];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/key_ring_buffer_with_inkey_encode.sv
// ============================================================================
// key_ring_buffer_with_inkey_encode - keyboard ring buffer, top level
// Posts key codes into a ring and reads them back inkey-encoded.
// ============================================================================
// Usage:
//   Slave stream: one beat per action. tuser carries the action (0 post,
//   1 read), tdata the 16-bit key code (ignored on a read).
//   Master stream: one beat per read, none per post. tdata carries
//   length [1:0], first byte [9:2], second byte [17:10], zeros above.
//   cfg_we/cfg_wdata write display_active; write it only while idle.
//   With display_active low a read answers length 0 and consumes nothing.
// Pipeline and throughput:
//   A beat is captured in the input register, processed against the ring
//   pointers and one table lookup, and its result lands in the output
//   register, which drives master tvalid.
//   One beat per cycle is sustained unless a read waits on a stalled master.
// Reset:
//   Pointers clear (ring empty), display_active clears, both stages empty.
//   Ring contents are not cleared; only written slots are ever read.
// Stall:
//   When the master side stalls, a held result keeps a read in the input
//   register; posts keep flowing. tready drops once the input register holds
//   a read that cannot move on.
// ============================================================================
`default_nettype none

module key_ring_buffer_with_inkey_encode (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,    // key_code [15:0]
    input  wire logic        s_axis_tuser,    // action [0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata     // length [1:0], first_byte [9:2],
                                              // second_byte [17:10], zero [23:18]
);
    import krb_pkg::*;

    logic             display_active_reg;
    logic             in_valid_reg;
    action_t          in_action_reg;
    logic [KEY_W-1:0] in_code_reg;
    logic             out_valid_reg;
    enc_t             out_data_reg;

    logic             advance;
    logic             s_beat;
    logic             m_beat;
    ring_op_t         op;
    ring_rsp_t        rsp;
    enc_t             enc;

    assign s_beat  = s_axis_tvalid && s_axis_tready;
    assign m_beat  = m_axis_tvalid && m_axis_tready;

    // a post never produces a result, so it never waits on the master side
    assign advance = in_valid_reg
                   && ((in_action_reg == ACT_POST) || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        op.post_en = advance && (in_action_reg == ACT_POST);
        op.read_en = advance && (in_action_reg == ACT_READ) && display_active_reg;
        op.code    = in_code_reg;
    end

    krb_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .rsp   (rsp)
    );

    krb_encode u_encode (
        .key (rsp.hit ? rsp.key : '0),
        .enc (enc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_active_reg <= 1'b0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                display_active_reg <= cfg_wdata;
            if (s_beat)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            // load a read result, drop a taken beat
            if (advance && (in_action_reg == ACT_READ))
                out_valid_reg <= 1'b1;
            else if (m_beat)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_action_reg <= action_t'(s_axis_tuser);
            in_code_reg   <= s_axis_tdata;
        end
        if (advance && (in_action_reg == ACT_READ))
            out_data_reg <= enc;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_data_reg.second_byte,
                            out_data_reg.first_byte, out_data_reg.length};

endmodule

`default_nettype wire
